@@ hw/rtl/lpi_pkg.sv @@
// ----------------------------------------------------------------------------
// lpi_pkg: shared constants for the line / plane intersection pipeline
// Stage counts of the pipeline sections and the quotient guard width.
// ----------------------------------------------------------------------------
package lpi_pkg;

    // register stages in the difference / dot product section
    localparam int FRONT_STAGES = 3;
    // register stages in the numerator scaling section
    localparam int SCALE_STAGES = 4;
    // register stages in the rounding / clipping section
    localparam int OUT_STAGES   = 2;
    // quotient bits kept beyond the coordinate width
    localparam int QUOT_EXTRA   = 2;

endpackage

@@ hw/rtl/lpi_in_if.sv @@
// ----------------------------------------------------------------------------
// lpi_in_if: query channel
// Valid / ready channel carrying one line / plane query per transaction.
// ----------------------------------------------------------------------------
interface lpi_in_if #(
    parameter int W = 32
);
    logic valid;
    logic ready;
    logic signed [W-1:0] line_a_x;
    logic signed [W-1:0] line_a_y;
    logic signed [W-1:0] line_a_z;
    logic signed [W-1:0] line_b_x;
    logic signed [W-1:0] line_b_y;
    logic signed [W-1:0] line_b_z;
    logic signed [W-1:0] plane_pt_x;
    logic signed [W-1:0] plane_pt_y;
    logic signed [W-1:0] plane_pt_z;
    logic signed [W-1:0] normal_x;
    logic signed [W-1:0] normal_y;
    logic signed [W-1:0] normal_z;

    modport source (
        output valid, line_a_x, line_a_y, line_a_z, line_b_x, line_b_y, line_b_z,
               plane_pt_x, plane_pt_y, plane_pt_z, normal_x, normal_y, normal_z,
        input  ready
    );
    modport sink (
        input  valid, line_a_x, line_a_y, line_a_z, line_b_x, line_b_y, line_b_z,
               plane_pt_x, plane_pt_y, plane_pt_z, normal_x, normal_y, normal_z,
        output ready
    );
endinterface

@@ hw/rtl/lpi_out_if.sv @@
// ----------------------------------------------------------------------------
// lpi_out_if: result channel
// Valid / ready channel carrying one intersection result per transaction.
// ----------------------------------------------------------------------------
interface lpi_out_if #(
    parameter int W = 32
);
    logic valid;
    logic ready;
    logic found;
    logic signed [W-1:0] hit_x;
    logic signed [W-1:0] hit_y;
    logic signed [W-1:0] hit_z;
    logic saturated;

    modport source (
        output valid, found, hit_x, hit_y, hit_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, found, hit_x, hit_y, hit_z, saturated,
        output ready
    );
endinterface

@@ hw/rtl/lpi_front.sv @@
// ----------------------------------------------------------------------------
// lpi_front: direction, products and dot products
// Three stages: differences, per-axis products, sums for den and num.
// ----------------------------------------------------------------------------
module lpi_front #(
    parameter int W = 32
) (
    input  logic                   clk,
    input  logic [lpi_pkg::FRONT_STAGES-1:0] en,
    input  logic signed [W-1:0]    a [3],
    input  logic signed [W-1:0]    b [3],
    input  logic signed [W-1:0]    c [3],
    input  logic signed [W-1:0]    n [3],
    output logic signed [W-1:0]    a_o [3],
    output logic signed [W:0]      d_o [3],
    output logic signed [2*W+3:0]  den,
    output logic signed [2*W+3:0]  num
);
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int NW = PW + 2;

    logic signed [W-1:0]  a0_reg [3];
    logic signed [DW-1:0] d0_reg [3];
    logic signed [DW-1:0] e0_reg [3];
    logic signed [W-1:0]  n0_reg [3];
    logic signed [W-1:0]  a1_reg [3];
    logic signed [DW-1:0] d1_reg [3];
    logic signed [PW-1:0] pd_reg [3];
    logic signed [PW-1:0] pn_reg [3];
    logic signed [W-1:0]  a2_reg [3];
    logic signed [DW-1:0] d2_reg [3];
    logic signed [NW-1:0] den_reg;
    logic signed [NW-1:0] num_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                a0_reg[i] <= a[i];
                n0_reg[i] <= n[i];
                d0_reg[i] <= DW'(a[i]) - DW'(b[i]);
                e0_reg[i] <= DW'(c[i]) - DW'(a[i]);
            end
        end
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                a1_reg[i] <= a0_reg[i];
                d1_reg[i] <= d0_reg[i];
                pd_reg[i] <= PW'(n0_reg[i]) * PW'(d0_reg[i]);
                pn_reg[i] <= PW'(n0_reg[i]) * PW'(e0_reg[i]);
            end
        end
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                a2_reg[i] <= a1_reg[i];
                d2_reg[i] <= d1_reg[i];
            end
            den_reg <= NW'(pd_reg[0]) + NW'(pd_reg[1]) + NW'(pd_reg[2]);
            num_reg <= NW'(pn_reg[0]) + NW'(pn_reg[1]) + NW'(pn_reg[2]);
        end
    end

    assign a_o = a2_reg;
    assign d_o = d2_reg;
    assign den = den_reg;
    assign num = num_reg;

endmodule

@@ hw/rtl/lpi_scale.sv @@
// ----------------------------------------------------------------------------
// lpi_scale: per-axis numerator scaling
// Forms D_i * num from two partial products, then magnitudes and the
// quotient range check ahead of the divider.
// ----------------------------------------------------------------------------
module lpi_scale #(
    parameter int W = 32
) (
    input  logic                     clk,
    input  logic [lpi_pkg::SCALE_STAGES-1:0] en,
    input  logic signed [W-1:0]      a,
    input  logic signed [W:0]        d,
    input  logic signed [2*W+3:0]    num,
    input  logic signed [2*W+3:0]    den,
    output logic signed [W-1:0]      a_o,
    output logic [3*W+4:0]           pm_o,
    output logic [2*W+3:0]           dm_o,
    output logic                     neg_o,
    output logic                     dz_o,
    output logic                     ovf_o
);
    localparam int DW  = W + 1;
    localparam int NW  = 2 * DW + 2;
    localparam int LW  = 2 * DW;
    localparam int HW  = DW + NW - W;
    localparam int P3W = DW + NW;
    localparam int QB  = W + lpi_pkg::QUOT_EXTRA;
    localparam int RW  = NW + QB;

    logic signed [LW-1:0]  lo_reg;
    logic signed [HW-1:0]  hi_reg;
    logic signed [W-1:0]   a0_reg, a1_reg, a2_reg, a3_reg;
    logic signed [NW-1:0]  den0_reg, den1_reg;
    logic signed [P3W-1:0] p_reg;
    logic [P3W-1:0]        pm_reg, pm3_reg;
    logic [NW-1:0]         dm_reg, dm3_reg;
    logic                  neg_reg, neg3_reg, dz_reg, dz3_reg, ovf_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lo_reg   <= LW'(d) * LW'($signed({1'b0, num[W-1:0]}));
            hi_reg   <= HW'(d) * HW'($signed(num[NW-1:W]));
            a0_reg   <= a;
            den0_reg <= den;
        end
        if (en[1])
        begin
            p_reg    <= (P3W'(hi_reg) <<< W) + P3W'(lo_reg);
            a1_reg   <= a0_reg;
            den1_reg <= den0_reg;
        end
        if (en[2])
        begin
            pm_reg  <= p_reg[P3W-1] ? P3W'(-p_reg) : P3W'(p_reg);
            dm_reg  <= den1_reg[NW-1] ? NW'(-den1_reg) : NW'(den1_reg);
            neg_reg <= p_reg[P3W-1] ^ den1_reg[NW-1];
            dz_reg  <= (den1_reg == '0);
            a2_reg  <= a1_reg;
        end
        if (en[3])
        begin
            // quotient needs more than QB bits: clip without dividing
            ovf_reg  <= (RW'(pm_reg) >= {dm_reg, {QB{1'b0}}});
            pm3_reg  <= pm_reg;
            dm3_reg  <= dm_reg;
            neg3_reg <= neg_reg;
            dz3_reg  <= dz_reg;
            a3_reg   <= a2_reg;
        end
    end

    assign a_o   = a3_reg;
    assign pm_o  = pm3_reg;
    assign dm_o  = dm3_reg;
    assign neg_o = neg3_reg;
    assign dz_o  = dz3_reg;
    assign ovf_o = ovf_reg;

endmodule

@@ hw/rtl/lpi_div.sv @@
// ----------------------------------------------------------------------------
// lpi_div: pipelined restoring divider
// One quotient bit per stage, most significant first.
// ----------------------------------------------------------------------------
module lpi_div #(
    parameter int W = 32
) (
    input  logic                   clk,
    input  logic [W+lpi_pkg::QUOT_EXTRA-1:0] en,
    input  logic signed [W-1:0]    a,
    input  logic [3*W+4:0]         pm,
    input  logic [2*W+3:0]         dm,
    input  logic                   neg,
    input  logic                   dz,
    input  logic                   ovf,
    output logic signed [W-1:0]    a_o,
    output logic [3*W+5:0]         rem_o,
    output logic [W+lpi_pkg::QUOT_EXTRA-1:0] q_o,
    output logic [2*W+3:0]         dm_o,
    output logic                   neg_o,
    output logic                   dz_o,
    output logic                   ovf_o
);
    localparam int NW = 2 * W + 4;
    localparam int QB = W + lpi_pkg::QUOT_EXTRA;
    localparam int RW = NW + QB;

    logic [RW-1:0]       rem_reg [QB];
    logic [QB-1:0]       q_reg   [QB];
    logic [NW-1:0]       dm_reg  [QB];
    logic signed [W-1:0] a_reg   [QB];
    logic                neg_reg [QB];
    logic                dz_reg  [QB];
    logic                ovf_reg [QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [RW-1:0]       rem_in;
        logic [QB-1:0]       q_in;
        logic [NW-1:0]       dm_in;
        logic signed [W-1:0] a_in;
        logic                neg_in, dz_in, ovf_in;
        logic [RW-1:0]       shifted;
        logic                ge;
        logic [RW-1:0]       rem_next;
        logic [QB-1:0]       q_next;

        if (k == 0)
        begin : g_first
            assign rem_in = RW'(pm);
            assign q_in   = '0;
            assign dm_in  = dm;
            assign a_in   = a;
            assign neg_in = neg;
            assign dz_in  = dz;
            assign ovf_in = ovf;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign dm_in  = dm_reg[k-1];
            assign a_in   = a_reg[k-1];
            assign neg_in = neg_reg[k-1];
            assign dz_in  = dz_reg[k-1];
            assign ovf_in = ovf_reg[k-1];
        end

        always_comb
        begin
            shifted = RW'(dm_in) << (QB - 1 - k);
            ge = (rem_in >= shifted);
            rem_next = ge ? rem_in - shifted : rem_in;
            q_next = q_in;
            q_next[QB-1-k] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k] <= rem_next;
                q_reg[k]   <= q_next;
                dm_reg[k]  <= dm_in;
                a_reg[k]   <= a_in;
                neg_reg[k] <= neg_in;
                dz_reg[k]  <= dz_in;
                ovf_reg[k] <= ovf_in;
            end
        end
    end

    assign a_o   = a_reg[QB-1];
    assign rem_o = rem_reg[QB-1];
    assign q_o   = q_reg[QB-1];
    assign dm_o  = dm_reg[QB-1];
    assign neg_o = neg_reg[QB-1];
    assign dz_o  = dz_reg[QB-1];
    assign ovf_o = ovf_reg[QB-1];

endmodule

@@ hw/rtl/lpi_out.sv @@
// ----------------------------------------------------------------------------
// lpi_out: rounding, offset and clipping
// Rounds the quotient half away from zero, adds the line point and
// saturates to the coordinate range.
// ----------------------------------------------------------------------------
module lpi_out #(
    parameter int W = 32
) (
    input  logic                   clk,
    input  logic [lpi_pkg::OUT_STAGES-1:0] en,
    input  logic signed [W-1:0]    a,
    input  logic [3*W+5:0]         rem,
    input  logic [W+lpi_pkg::QUOT_EXTRA-1:0] q,
    input  logic [2*W+3:0]         dm,
    input  logic                   neg,
    input  logic                   dz,
    input  logic                   ovf,
    output logic signed [W-1:0]    hit,
    output logic                   sat,
    output logic                   found
);
    localparam int NW = 2 * W + 4;
    localparam int QB = W + lpi_pkg::QUOT_EXTRA;
    localparam int RW = NW + QB;
    localparam int SW = W + 4;
    localparam logic signed [SW-1:0] HI_LIM = (SW'(1) <<< (W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] LO_LIM = -(SW'(1) <<< (W - 1));

    logic [QB:0]          qm_reg;
    logic signed [W-1:0]  a_reg;
    logic                 neg_reg, dz_reg, ovf_reg;
    logic                 rnd;
    logic signed [SW-1:0] qs;
    logic signed [SW-1:0] sum;
    logic signed [W-1:0]  hit_next;
    logic                 sat_next;
    logic signed [W-1:0]  hit_reg;
    logic                 sat_reg, found_reg;

    assign rnd = ({rem, 1'b0} >= (RW + 1)'(dm));

    always_comb
    begin
        qs  = neg_reg ? -SW'(qm_reg) : SW'(qm_reg);
        sum = SW'(a_reg) + qs;
        hit_next = sum[W-1:0];
        sat_next = 1'b0;
        if (dz_reg)
        begin
            hit_next = '0;
        end
        else if (ovf_reg)
        begin
            sat_next = 1'b1;
            hit_next = neg_reg ? LO_LIM[W-1:0] : HI_LIM[W-1:0];
        end
        else if (sum > HI_LIM)
        begin
            sat_next = 1'b1;
            hit_next = HI_LIM[W-1:0];
        end
        else if (sum < LO_LIM)
        begin
            sat_next = 1'b1;
            hit_next = LO_LIM[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            qm_reg  <= (QB + 1)'(q) + (QB + 1)'(rnd);
            a_reg   <= a;
            neg_reg <= neg;
            dz_reg  <= dz;
            ovf_reg <= ovf;
        end
        if (en[1])
        begin
            hit_reg   <= hit_next;
            sat_reg   <= sat_next;
            found_reg <= !dz_reg;
        end
    end

    assign hit   = hit_reg;
    assign sat   = sat_reg;
    assign found = found_reg;

endmodule

@@ hw/rtl/line_plane_intersection_top.sv @@
// ----------------------------------------------------------------------------
// line_plane_intersection_top: fixed-point line / plane intersection
// Each query (points A, B on a line, point C and normal N of a plane) gives
// one result: the intersection point, rounded and saturated, or found = 0
// when N . (A - B) is zero: the line is parallel to the plane, A = B or N = 0.
// Channels: req (query, sink) and rsp (result, source), valid / ready; a
//   transaction completes on a clock edge with valid and ready both high.
// Stages: 3 dot product, 4 scaling, one divider stage per quotient bit
//   (COORD_WIDTH + 2) and 2 rounding / clipping stages.
// Throughput: one query per cycle except while every stage is full and rsp
//   is not ready; the bit-per-stage divider sets the depth.
// Stall: when rsp is not ready, the last stage holds its result and earlier
//   stages keep advancing into empty slots, so req stays ready until every
//   stage is full. Nothing is dropped or repeated.
// Reset: rst_n clears all stage valid bits; the pipeline comes up empty.
// ----------------------------------------------------------------------------
module line_plane_intersection_top #(
    parameter int COORD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    lpi_in_if.sink      req,
    lpi_out_if.source   rsp
);
    localparam int W   = COORD_WIDTH;
    localparam int QB  = W + lpi_pkg::QUOT_EXTRA;
    localparam int SC0 = lpi_pkg::FRONT_STAGES;
    localparam int DV0 = SC0 + lpi_pkg::SCALE_STAGES;
    localparam int OU0 = DV0 + QB;
    localparam int NS  = OU0 + lpi_pkg::OUT_STAGES;

    logic [NS-1:0] valid_reg, valid_next;
    logic [NS-1:0] en;

    logic signed [W-1:0]     a_in [3], b_in [3], c_in [3], n_in [3];
    logic signed [W-1:0]     fa [3];
    logic signed [W:0]       fd [3];
    logic signed [2*W+3:0]   den, num;

    logic signed [W-1:0]     sa [3];
    logic [3*W+4:0]          spm [3];
    logic [2*W+3:0]          sdm [3];
    logic [2:0]              sneg, sdz, sovf;

    logic signed [W-1:0]     da [3];
    logic [3*W+5:0]          drem [3];
    logic [QB-1:0]           dq [3];
    logic [2*W+3:0]          ddm [3];
    logic [2:0]              dneg, ddz, dovf;

    logic signed [W-1:0]     hit [3];
    logic [2:0]              sat, found;

    // a stage advances when some stage at or after it is empty, or the
    // result is being taken
    for (genvar k = 0; k < NS; k++)
    begin : g_en
        assign en[k] = rsp.ready | ~(&valid_reg[NS-1:k]);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = req.valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign req.ready = en[0];

    assign a_in[0] = req.line_a_x;
    assign a_in[1] = req.line_a_y;
    assign a_in[2] = req.line_a_z;
    assign b_in[0] = req.line_b_x;
    assign b_in[1] = req.line_b_y;
    assign b_in[2] = req.line_b_z;
    assign c_in[0] = req.plane_pt_x;
    assign c_in[1] = req.plane_pt_y;
    assign c_in[2] = req.plane_pt_z;
    assign n_in[0] = req.normal_x;
    assign n_in[1] = req.normal_y;
    assign n_in[2] = req.normal_z;

    lpi_front #(.W(W)) u_front (
        .clk (clk),
        .en  (en[SC0-1:0]),
        .a   (a_in),
        .b   (b_in),
        .c   (c_in),
        .n   (n_in),
        .a_o (fa),
        .d_o (fd),
        .den (den),
        .num (num)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        lpi_scale #(.W(W)) u_scale (
            .clk   (clk),
            .en    (en[SC0 +: lpi_pkg::SCALE_STAGES]),
            .a     (fa[i]),
            .d     (fd[i]),
            .num   (num),
            .den   (den),
            .a_o   (sa[i]),
            .pm_o  (spm[i]),
            .dm_o  (sdm[i]),
            .neg_o (sneg[i]),
            .dz_o  (sdz[i]),
            .ovf_o (sovf[i])
        );

        lpi_div #(.W(W)) u_div (
            .clk   (clk),
            .en    (en[DV0 +: QB]),
            .a     (sa[i]),
            .pm    (spm[i]),
            .dm    (sdm[i]),
            .neg   (sneg[i]),
            .dz    (sdz[i]),
            .ovf   (sovf[i]),
            .a_o   (da[i]),
            .rem_o (drem[i]),
            .q_o   (dq[i]),
            .dm_o  (ddm[i]),
            .neg_o (dneg[i]),
            .dz_o  (ddz[i]),
            .ovf_o (dovf[i])
        );

        lpi_out #(.W(W)) u_out (
            .clk   (clk),
            .en    (en[OU0 +: lpi_pkg::OUT_STAGES]),
            .a     (da[i]),
            .rem   (drem[i]),
            .q     (dq[i]),
            .dm    (ddm[i]),
            .neg   (dneg[i]),
            .dz    (ddz[i]),
            .ovf   (dovf[i]),
            .hit   (hit[i]),
            .sat   (sat[i]),
            .found (found[i])
        );
    end

    assign rsp.valid     = valid_reg[NS-1];
    assign rsp.found     = found[0];
    assign rsp.hit_x     = hit[0];
    assign rsp.hit_y     = hit[1];
    assign rsp.hit_z     = hit[2];
    assign rsp.saturated = |sat;

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: line / plane intersection testbench
// Drives queries through the valid / ready request channel and predicts each
// intersection with exact wide-integer arithmetic. Every response is checked
// field by field against the oldest pending prediction. Directed corner cases
// come first, then random queries. Random idle gaps on both channels and a
// long response hold-off exercise the pipeline stall.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W         = 32;
    localparam int LATENCY   = lpi_pkg::FRONT_STAGES + lpi_pkg::SCALE_STAGES + W
                               + lpi_pkg::QUOT_EXTRA + lpi_pkg::OUT_STAGES;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic signed [W-1:0] CMAX = 32'sh7fffffff;
    localparam logic signed [W-1:0] CMIN = 32'sh80000000;

    typedef struct {
        logic signed [W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, nx, ny, nz;
    } query_t;

    typedef struct {
        logic                found;
        logic signed [W-1:0] hx, hy, hz;
        logic                sat;
    } hit_t;

    logic clk;
    logic rst_n;
    int   error_count;
    int   cycle_count;
    int   hold_cycles;
    int   stall_left;
    bit   no_stall;
    hit_t pending_hits[$];

    lpi_in_if  #(.W(W)) req ();
    lpi_out_if #(.W(W)) rsp ();

    line_plane_intersection_top #(.COORD_WIDTH(W)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // exact intersection: round each quotient to nearest, ties away from zero
    function automatic hit_t predict_hit(input query_t qy);
        logic signed [127:0] a[3], b[3], c[3], n[3], d[3], e[3];
        logic signed [127:0] den, num, p, sum;
        logic        [127:0] pm, dm, qm, rm;
        logic signed [127:0] qs;
        logic signed [W-1:0] coord[3];
        hit_t h;
        int i;
        a[0] = qy.ax; a[1] = qy.ay; a[2] = qy.az;
        b[0] = qy.bx; b[1] = qy.by; b[2] = qy.bz;
        c[0] = qy.cx; c[1] = qy.cy; c[2] = qy.cz;
        n[0] = qy.nx; n[1] = qy.ny; n[2] = qy.nz;
        h.found = 1'b0;
        h.hx = '0;
        h.hy = '0;
        h.hz = '0;
        h.sat = 1'b0;
        for (i = 0; i < 3; i++)
        begin
            d[i] = a[i] - b[i];
            e[i] = c[i] - a[i];
        end
        den = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
        if (den == 0)
            return h;
        num = e[0] * n[0] + e[1] * n[1] + e[2] * n[2];
        dm = (den < 0) ? -den : den;
        for (i = 0; i < 3; i++)
        begin
            p  = d[i] * num;
            pm = (p < 0) ? -p : p;
            qm = pm / dm;
            rm = pm % dm;
            if ((rm << 1) >= dm)
                qm = qm + 1;
            qs = ((p < 0) != (den < 0)) ? -$signed(qm) : $signed(qm);
            sum = a[i] + qs;
            if (sum > 128'sd2147483647)
            begin
                coord[i] = CMAX;
                h.sat = 1'b1;
            end
            else if (sum < -128'sd2147483648)
            begin
                coord[i] = CMIN;
                h.sat = 1'b1;
            end
            else
                coord[i] = sum[W-1:0];
        end
        h.found = 1'b1;
        h.hx = coord[0];
        h.hy = coord[1];
        h.hz = coord[2];
        return h;
    endfunction

    task automatic report_mismatch(input string field, input logic [W-1:0] got,
                                   input logic [W-1:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", field, got, want, cycle_count);
        error_count++;
    endtask

    // response side: random stalls, optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_cycles > 0)
        begin
            rsp.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (no_stall)
            rsp.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            rsp.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 9) < 7)
            rsp.ready <= 1'b1;
        else
        begin
            rsp.ready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                     : $urandom_range(3, 40);
        end
    end

    always @(posedge clk)
    begin
        hit_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_hits.size() == 0)
            begin
                $display("unexpected result at cycle %0d", cycle_count);
                error_count++;
            end
            else
            begin
                want = pending_hits.pop_front();
                if (rsp.found !== want.found)
                    report_mismatch("found", rsp.found, want.found);
                if (rsp.hit_x !== want.hx)
                    report_mismatch("hit_x", rsp.hit_x, want.hx);
                if (rsp.hit_y !== want.hy)
                    report_mismatch("hit_y", rsp.hit_y, want.hy);
                if (rsp.hit_z !== want.hz)
                    report_mismatch("hit_z", rsp.hit_z, want.hz);
                if (rsp.saturated !== want.sat)
                    report_mismatch("saturated", rsp.saturated, want.sat);
            end
        end
    end

    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 40);
    endfunction

    function automatic logic signed [W-1:0] rand_coord();
        logic signed [W-1:0] v;
        case ($urandom_range(0, 6))
            0, 1:    v = $urandom;
            2, 3:    v = $signed($urandom_range(0, 2097151)) - 32'sd1048576;
            4:       v = $urandom_range(0, 1) ? CMAX : CMIN;
            5:       v = '0;
            default: v = ($urandom_range(0, 1) ? 32'sd1 : -32'sd1) <<< $urandom_range(0, 30);
        endcase
        return v;
    endfunction

    function automatic query_t rand_query();
        query_t qy;
        qy.ax = rand_coord(); qy.ay = rand_coord(); qy.az = rand_coord();
        qy.bx = rand_coord(); qy.by = rand_coord(); qy.bz = rand_coord();
        qy.cx = rand_coord(); qy.cy = rand_coord(); qy.cz = rand_coord();
        qy.nx = rand_coord(); qy.ny = rand_coord(); qy.nz = rand_coord();
        // some lines run along z over a plane whose normal has no z part
        if ($urandom_range(0, 9) == 0)
        begin
            qy.bx = qy.ax;
            qy.by = qy.ay;
            qy.nz = '0;
        end
        return qy;
    endfunction

    task automatic send_query(input query_t qy, input int gap);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.line_a_x   <= qy.ax; req.line_a_y   <= qy.ay; req.line_a_z   <= qy.az;
        req.line_b_x   <= qy.bx; req.line_b_y   <= qy.by; req.line_b_z   <= qy.bz;
        req.plane_pt_x <= qy.cx; req.plane_pt_y <= qy.cy; req.plane_pt_z <= qy.cz;
        req.normal_x   <= qy.nx; req.normal_y   <= qy.ny; req.normal_z   <= qy.nz;
        do
            @(posedge clk);
        while (!req.ready);
        pending_hits.push_back(predict_hit(qy));
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
    endtask

    function automatic query_t make_query(input logic signed [W-1:0] ax, ay, az, bx, by, bz,
                                          cx, cy, cz, nx, ny, nz);
        query_t qy;
        qy.ax = ax; qy.ay = ay; qy.az = az;
        qy.bx = bx; qy.by = by; qy.bz = bz;
        qy.cx = cx; qy.cy = cy; qy.cz = cz;
        qy.nx = nx; qy.ny = ny; qy.nz = nz;
        return qy;
    endfunction

    task automatic test_directed();
        localparam logic signed [W-1:0] ONE = 32'sh00010000;
        // simple hit on z = 0 plane
        send_query(make_query(0, 0, ONE, 0, 0, -ONE, 0, 0, 0, 0, 0, ONE), 0);
        // coincident points
        send_query(make_query(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE), 1);
        // zero normal
        send_query(make_query(ONE, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 0), 0);
        // parallel, off the plane
        send_query(make_query(0, 0, ONE, ONE, 0, ONE, 0, 0, 0, 0, 0, ONE), 0);
        // line inside the plane
        send_query(make_query(0, 0, 0, ONE, ONE, 0, 5, 7, 0, 0, 0, ONE), 2);
        // extremes everywhere
        send_query(make_query(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
                              CMIN, CMAX, CMIN, CMAX, CMIN, CMAX), 0);
        send_query(make_query(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                              CMAX, CMAX, CMAX, CMIN, CMIN, CMIN), 0);
        send_query(make_query(CMIN, CMAX, 0, CMAX, CMIN, 0,
                              CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 0);
        // nearly parallel line: far hit at the edge of the coordinate range
        send_query(make_query(0, 0, 1, CMAX, 0, 0, 0, 0, 0, 0, 0, ONE), 3);
        send_query(make_query(0, 0, -1, CMIN, CMIN, 0, 0, 0, 0, 0, 0, ONE), 0);
        // rounding ties: t = 1/2 on an odd step, then an exact t = 2/3
        send_query(make_query(1, 0, 2, 0, 0, 0, 0, 0, 1, 0, 0, 1), 0);
        send_query(make_query(-1, 0, 2, 0, 0, 0, 0, 0, 1, 0, 0, 1), 0);
        send_query(make_query(3, 0, 3, 0, 0, 0, 0, 0, 1, 0, 0, 1), 0);
        // all zero
        send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        // all ones pattern, then mixed with zeros and CMAX
        send_query(make_query(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1), 0);
        send_query(make_query(-1, -1, -1, 0, 0, 0, CMAX, CMAX, CMAX, -1, -1, -1), 0);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        int i;
        int burst;
        burst = 0;
        for (i = 0; i < count; i++)
        begin
            if (burst == 0 && $urandom_range(0, 19) == 0)
            begin
                burst = $urandom_range(20, 60);
                no_stall <= 1'b1;
            end
            if (burst > 0)
            begin
                burst--;
                if (burst == 0)
                    no_stall <= 1'b0;
                send_query(rand_query(), 0);
            end
            else
                send_query(rand_query(), pick_gap());
        end
        no_stall <= 1'b0;
    endtask

    task automatic test_backpressure();
        int i;
        hold_cycles <= 4 * LATENCY;
        for (i = 0; i < 3 * LATENCY; i++)
            send_query(rand_query(), 0);
        wait_drained();
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        no_stall    = 1'b0;
        rst_n       = 1'b0;
        req.valid      = 1'b0;
        req.line_a_x   = '0; req.line_a_y   = '0; req.line_a_z   = '0;
        req.line_b_x   = '0; req.line_b_y   = '0; req.line_b_z   = '0;
        req.plane_pt_x = '0; req.plane_pt_y = '0; req.plane_pt_z = '0;
        req.normal_x   = '0; req.normal_y   = '0; req.normal_z   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(700);
        test_backpressure();
        test_random(750);
        wait_drained();
        repeat (LATENCY + 20) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
